// File: src/tlbr_pkg.sv
// shared types, codes and default sizes of the translation buffer
`default_nettype none

package tlbr_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int PAGE_BITS_DEF  = 8;
  localparam int FRAME_BITS_DEF = 8;
  localparam int QUEUE_DEPTH    = 2;

  localparam int PAGE_W  = 8;
  localparam int FRAME_W = 8;
  localparam int SLOT_W  = 4;
  localparam int AGE_W   = 8;

  localparam logic [AGE_W-1:0] AGE_MAX = 8'hFF;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  localparam logic POLICY_AGE  = 1'b0;
  localparam logic POLICY_RING = 1'b1;

  typedef enum logic [1:0] {
    OP_LOOKUP,
    OP_INS_AGE,
    OP_INS_RING
  } op_e;

  typedef struct packed {
    logic               command;
    logic [PAGE_W-1:0]  vpage;
    logic [FRAME_W-1:0] frame_number;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame_out;
    logic [SLOT_W-1:0]  slot_written;
  } rsp_t;

endpackage

`default_nettype wire

// File: src/tlb_lookup_with_replacement_unit.sv
// fully associative translation buffer with age or ring replacement
//
//   port group                     dir   contents
//   push / full / req_i            in    request: command, page, frame
//   empty / pop / rsp_o            out   result: hit, frame, slot written
//   cfg_valid_i / cfg_ready_o      in    replacement policy bit (cfg_data_i)
//
// a lookup, a ring insert or an age insert while entries are free completes in the run state
// an age insert into a full buffer: age bump, then the oldest-entry search in the victim state
// a result reaches rsp_o via intake register, command queue, back end and result queue
// reset clears valid bits, ages, fill count, ring pointer and the policy; no clearing pass
// intake and back end stall separately, joined by a two-deep command queue
`default_nettype none

module tlb_lookup_with_replacement_unit #(
  parameter int ENTRIES    = tlbr_pkg::ENTRIES_DEF,
  parameter int PAGE_BITS  = tlbr_pkg::PAGE_BITS_DEF,
  parameter int FRAME_BITS = tlbr_pkg::FRAME_BITS_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push,
  input  wire tlbr_pkg::req_t req_i,
  output logic                full,
  output logic                empty,
  input  wire logic           pop,
  output tlbr_pkg::rsp_t      rsp_o,
  input  wire logic           cfg_valid_i,
  input  wire logic           cfg_data_i,
  output logic                cfg_ready_o
);

  import tlbr_pkg::*;

  typedef struct packed {
    op_e                   op;
    logic [PAGE_BITS-1:0]  page;
    logic [FRAME_BITS-1:0] frame;
  } cmd_t;

  logic cmd_push;
  cmd_t cmd_in;
  logic cmd_full;
  logic cmd_pop;
  cmd_t cmd_out;
  logic cmd_empty;
  logic res_push;
  rsp_t res_in;
  logic res_full;

  tlbr_front #(
    .cmd_t      (cmd_t),
    .PAGE_BITS  (PAGE_BITS),
    .FRAME_BITS (FRAME_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .req_i       (req_i),
    .full_o      (full),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in),
    .cmd_full_i  (cmd_full)
  );

  tlbr_fifo #(
    .T     (cmd_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  tlbr_back #(
    .cmd_t      (cmd_t),
    .ENTRIES    (ENTRIES),
    .PAGE_BITS  (PAGE_BITS),
    .FRAME_BITS (FRAME_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  tlbr_fifo #(
    .T     (rsp_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (rsp_o),
    .empty_o (empty)
  );

endmodule

`default_nettype wire

// File: src/tlbr_fifo.sv
// small first-in first-out queue of registers
`default_nettype none

module tlbr_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire T     data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output T          data_o,
  output logic      empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  T                 mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push_ok;
  logic             pop_ok;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: src/tlbr_front.sv
// request intake, policy register and command classification
`default_nettype none

module tlbr_front #(
  parameter type cmd_t      = logic,
  parameter int  PAGE_BITS  = tlbr_pkg::PAGE_BITS_DEF,
  parameter int  FRAME_BITS = tlbr_pkg::FRAME_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire tlbr_pkg::req_t req_i,
  output logic               full_o,
  input  wire logic          cfg_valid_i,
  input  wire logic          cfg_data_i,
  output logic               cfg_ready_o,
  output logic               cmd_push_o,
  output cmd_t               cmd_o,
  input  wire logic          cmd_full_i
);

  import tlbr_pkg::*;

  logic policy_q;
  logic vld_q, vld_d;
  cmd_t cmd_q;
  cmd_t cmd_s;
  logic accept;

  assign cfg_ready_o = 1'b1;
  assign full_o      = vld_q && cmd_full_i;
  assign accept      = push_i && !full_o;
  assign cmd_push_o  = vld_q;
  assign cmd_o       = cmd_q;

  always_comb begin
    cmd_s       = '0;
    cmd_s.page  = PAGE_BITS'(req_i.vpage);
    cmd_s.frame = FRAME_BITS'(req_i.frame_number);
    if (req_i.command == CMD_LOOKUP) begin
      cmd_s.op = OP_LOOKUP;
    end else if (policy_q == POLICY_AGE) begin
      cmd_s.op = OP_INS_AGE;
    end else begin
      cmd_s.op = OP_INS_RING;
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (vld_q && !cmd_full_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POLICY_AGE;
      vld_q    <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        policy_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_s;
    end
  end

endmodule

`default_nettype wire

// File: src/tlbr_back.sv
// entry store, lookup compare and replacement execution
`default_nettype none

module tlbr_back #(
  parameter type cmd_t      = logic,
  parameter int  ENTRIES    = tlbr_pkg::ENTRIES_DEF,
  parameter int  PAGE_BITS  = tlbr_pkg::PAGE_BITS_DEF,
  parameter int  FRAME_BITS = tlbr_pkg::FRAME_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_empty_i,
  input  wire cmd_t cmd_i,
  output logic      cmd_pop_o,
  input  wire logic res_full_i,
  output logic      res_push_o,
  output tlbr_pkg::rsp_t res_o
);

  import tlbr_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int LEAVES = 1 << IDX_W;

  localparam logic ST_RUN    = 1'b0;
  localparam logic ST_VICTIM = 1'b1;

  typedef struct packed {
    logic             vld;
    logic [AGE_W-1:0] age;
    logic [IDX_W-1:0] idx;
  } node_t;

  logic                  state_q, state_d;
  logic [ENTRIES-1:0]    valid_q;
  logic [PAGE_BITS-1:0]  page_q  [ENTRIES];
  logic [FRAME_BITS-1:0] frame_q [ENTRIES];
  logic [AGE_W-1:0]      age_q   [ENTRIES];
  logic [CNT_W-1:0]      fill_q;
  logic [IDX_W-1:0]      ring_q;

  logic                  take;
  logic                  filled;
  logic                  lk_hit;
  logic [FRAME_BITS-1:0] lk_frame;
  node_t                 leaf_s [LEAVES];
  node_t                 node_s [LEAVES-1];
  logic [IDX_W-1:0]      vic_idx;

  logic                  wr_en;
  logic                  age_wr;
  logic [IDX_W-1:0]      wr_slot;
  logic                  bump;
  logic                  fill_inc;
  logic                  ring_adv;

  assign take    = (state_q == ST_RUN) && !cmd_empty_i && !res_full_i;
  assign filled  = (fill_q == CNT_W'(ENTRIES));
  assign vic_idx = node_s[0].idx;

  // highest matching index wins
  always_comb begin
    lk_hit   = 1'b0;
    lk_frame = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (valid_q[i] && (page_q[i] == cmd_i.page)) begin
        lk_hit   = 1'b1;
        lk_frame = frame_q[i];
      end
    end
  end

  // oldest entry search, lower index kept on a tie
  for (genvar g = 0; g < LEAVES; g++) begin : g_leaf
    if (g < ENTRIES) begin : g_used
      assign leaf_s[g] = '{vld: 1'b1, age: age_q[g], idx: IDX_W'(g)};
    end else begin : g_pad
      assign leaf_s[g] = '{vld: 1'b0, age: '0, idx: IDX_W'(g)};
    end
  end

  always_comb begin
    node_t lt;
    node_t rt;
    for (int n = LEAVES - 2; n >= 0; n--) begin
      lt = (2 * n + 1 >= LEAVES - 1) ? leaf_s[2 * n + 1 - (LEAVES - 1)] : node_s[2 * n + 1];
      rt = (2 * n + 2 >= LEAVES - 1) ? leaf_s[2 * n + 2 - (LEAVES - 1)] : node_s[2 * n + 2];
      if (rt.vld && (!lt.vld || (rt.age > lt.age))) begin
        node_s[n] = rt;
      end else begin
        node_s[n] = lt;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    wr_en      = 1'b0;
    age_wr     = 1'b0;
    wr_slot    = '0;
    bump       = 1'b0;
    fill_inc   = 1'b0;
    ring_adv   = 1'b0;
    case (state_q)
      ST_RUN: begin
        if (take) begin
          case (cmd_i.op)
            OP_LOOKUP: begin
              cmd_pop_o       = 1'b1;
              res_push_o      = 1'b1;
              res_o.hit       = lk_hit;
              res_o.frame_out = FRAME_W'(lk_frame);
            end
            OP_INS_AGE: begin
              bump = 1'b1;
              if (filled) begin
                state_d = ST_VICTIM;
              end else begin
                wr_en              = 1'b1;
                age_wr             = 1'b1;
                wr_slot            = fill_q[IDX_W-1:0];
                fill_inc           = 1'b1;
                cmd_pop_o          = 1'b1;
                res_push_o         = 1'b1;
                res_o.slot_written = SLOT_W'(fill_q[IDX_W-1:0]);
              end
            end
            OP_INS_RING: begin
              wr_en              = 1'b1;
              wr_slot            = ring_q;
              ring_adv           = 1'b1;
              cmd_pop_o          = 1'b1;
              res_push_o         = 1'b1;
              res_o.slot_written = SLOT_W'(ring_q);
            end
            default: begin
              cmd_pop_o  = 1'b1;
              res_push_o = 1'b1;
            end
          endcase
        end
      end
      ST_VICTIM: begin
        wr_en              = 1'b1;
        age_wr             = 1'b1;
        wr_slot            = vic_idx;
        cmd_pop_o          = 1'b1;
        res_push_o         = 1'b1;
        res_o.slot_written = SLOT_W'(vic_idx);
        state_d            = ST_RUN;
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      valid_q <= '0;
      fill_q  <= '0;
      ring_q  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        age_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (wr_en) begin
        valid_q[wr_slot] <= 1'b1;
      end
      if (fill_inc) begin
        fill_q <= fill_q + 1'b1;
      end
      if (ring_adv) begin
        ring_q <= (ring_q == IDX_W'(ENTRIES - 1)) ? '0 : ring_q + 1'b1;
      end
      for (int i = 0; i < ENTRIES; i++) begin
        if (age_wr && (wr_slot == IDX_W'(i))) begin
          age_q[i] <= '0;
        end else if (bump && (CNT_W'(i) < fill_q) && (age_q[i] != AGE_MAX)) begin
          age_q[i] <= age_q[i] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      page_q[wr_slot]  <= cmd_i.page;
      frame_q[wr_slot] <= cmd_i.frame;
    end
  end

  a_victim_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_VICTIM |-> !res_full_i && !cmd_empty_i)
    else $error("victim cycle without room or command");

  a_victim_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_VICTIM |=> state_q == ST_RUN)
    else $error("victim search did not finish");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(ENTRIES))
    else $error("fill count beyond entries");

  a_pop_with_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o == res_push_o)
    else $error("command retired without a result");

  a_insert_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && wr_en |-> !res_o.hit && res_o.frame_out == '0)
    else $error("insert result carries a hit");

endmodule

`default_nettype wire

// File: test/tlbr_checker.sv
// checker for the translation buffer: tracks requests, predicts results and compares them
module tlbr_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  logic           full_i,
  input  tlbr_pkg::req_t req_i,
  input  logic           pop_i,
  input  logic           empty_i,
  input  tlbr_pkg::rsp_t rsp_i,
  input  logic           cfg_valid_i,
  input  logic           cfg_ready_i,
  input  logic           cfg_data_i,
  output int             mismatches_o,
  output int             pending_o,
  output int             checked_o,
  output int             hits_o,
  output int             evictions_o
);

  import tlbr_pkg::*;

  localparam int N = ENTRIES_DEF;

  logic               policy;
  logic               entry_valid [N];
  logic [PAGE_W-1:0]  entry_page  [N];
  logic [FRAME_W-1:0] entry_frame [N];
  logic [AGE_W-1:0]   entry_age   [N];
  logic [4:0]         fill_count;
  logic [SLOT_W-1:0]  ring_ptr;
  rsp_t               expected_rsp_q [$];

  function automatic rsp_t translate_request(input req_t r);
    rsp_t             res;
    logic [SLOT_W-1:0] slot;
    logic [AGE_W-1:0] oldest;
    res = '0;
    slot = '0;
    if (r.command == CMD_LOOKUP) begin
      for (int i = 0; i < N; i++) begin
        if (entry_valid[i] && entry_page[i] == r.vpage) begin
          res.hit = 1'b1;
          res.frame_out = entry_frame[i];
        end
      end
    end else begin
      if (policy == POLICY_AGE) begin
        for (int i = 0; i < N; i++) begin
          if (i < fill_count && entry_age[i] != AGE_MAX) entry_age[i] = entry_age[i] + 1'b1;
        end
        if (fill_count >= N) begin
          // oldest entry, lowest index on a tie
          oldest = '0;
          for (int i = 0; i < N; i++) begin
            if (entry_age[i] > oldest) begin
              oldest = entry_age[i];
              slot = SLOT_W'(i);
            end
          end
          evictions_o++;
        end else begin
          slot = SLOT_W'(fill_count);
          fill_count = fill_count + 1'b1;
        end
        entry_age[slot] = '0;
      end else begin
        slot = ring_ptr;
        ring_ptr = (ring_ptr == SLOT_W'(N - 1)) ? '0 : ring_ptr + 1'b1;
      end
      entry_page[slot] = r.vpage;
      entry_frame[slot] = r.frame_number;
      entry_valid[slot] = 1'b1;
      res.slot_written = slot;
    end
    return res;
  endfunction

  task automatic check_result(input rsp_t got);
    rsp_t want;
    if (expected_rsp_q.size() == 0) begin
      if (mismatches_o < 10)
        $display("unexpected result: hit=%0b frame=%02h slot=%0d",
                 got.hit, got.frame_out, got.slot_written);
      mismatches_o++;
      return;
    end
    want = expected_rsp_q.pop_front();
    pending_o--;
    checked_o++;
    if (want.hit) hits_o++;
    if (got.hit !== want.hit || got.frame_out !== want.frame_out ||
        got.slot_written !== want.slot_written) begin
      if (mismatches_o < 10)
        $display({"mismatch on result %0d: expected hit=%0b frame=%02h slot=%0d, ",
                  "got hit=%0b frame=%02h slot=%0d"},
                 checked_o, want.hit, want.frame_out, want.slot_written,
                 got.hit, got.frame_out, got.slot_written);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy = POLICY_AGE;
      for (int i = 0; i < N; i++) begin
        entry_valid[i] = 1'b0;
        entry_page[i] = '0;
        entry_frame[i] = '0;
        entry_age[i] = '0;
      end
      fill_count = '0;
      ring_ptr = '0;
      expected_rsp_q.delete();
      mismatches_o = 0;
      pending_o = 0;
      checked_o = 0;
      hits_o = 0;
      evictions_o = 0;
    end else begin
      if (pop_i && !empty_i) check_result(rsp_i);
      if (cfg_valid_i && cfg_ready_i) policy = cfg_data_i;
      if (push_i && !full_i) begin
        expected_rsp_q.push_back(translate_request(req_i));
        pending_o++;
      end
    end
  end

endmodule

// File: test/tb_tlb_lookup_with_replacement_unit.sv
// testbench top for the translation buffer: stimulus, idling, watchdog and verdict
module tb_tlb_lookup_with_replacement_unit;
  import tlbr_pkg::*;

  localparam int GAP_MAX       = 11;
  localparam int RANDOM_ITEMS  = 1550;
  localparam int PHASES        = 6;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_LIMIT    = 4000;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic push      = 1'b0;
  logic pop       = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_data  = 1'b0;
  req_t req       = '0;
  logic full, empty, cfg_ready;
  rsp_t rsp;

  int mismatches, pending, checked, hits, evictions;
  int sent          = 0;
  int policy_writes = 0;
  int idle_cycles   = 0;
  bit push_burst    = 1'b0;
  bit pop_burst     = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  tlb_lookup_with_replacement_unit u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .req_i      (req),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .rsp_o      (rsp),
    .cfg_valid_i(cfg_valid),
    .cfg_data_i (cfg_data),
    .cfg_ready_o(cfg_ready)
  );

  tlbr_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .push_i      (push),
    .full_i      (full),
    .req_i       (req),
    .pop_i       (pop),
    .empty_i     (empty),
    .rsp_i       (rsp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .mismatches_o(mismatches),
    .pending_o   (pending),
    .checked_o   (checked),
    .hits_o      (hits),
    .evictions_o (evictions)
  );

  function automatic int draw_gap(input bit burst);
    return burst ? 0 : int'($urandom_range(0, GAP_MAX));
  endfunction

  // entered and left at a falling edge
  task automatic send_request(input logic command, input logic [PAGE_W-1:0] page,
                              input logic [FRAME_W-1:0] frame);
    int gap;
    if ($urandom_range(0, 39) == 0) push_burst = !push_burst;
    gap = draw_gap(push_burst);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    req <= '{command: command, vpage: page, frame_number: frame};
    @(posedge clk);
    while (full) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_policy(input logic value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    policy_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // pages mostly from a small window so lookups hit and the buffer fills
  task automatic run_phase(input int count);
    logic [PAGE_W-1:0] base;
    logic [PAGE_W-1:0] page;
    logic              command;
    base = PAGE_W'($urandom_range(0, 255));
    for (int i = 0; i < count; i++) begin
      command = ($urandom_range(0, 99) < 45) ? CMD_INSERT : CMD_LOOKUP;
      if ($urandom_range(0, 4) == 0) page = PAGE_W'($urandom_range(0, 255));
      else page = base + PAGE_W'($urandom_range(0, 23));
      send_request(command, page, FRAME_W'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) pop_burst = !pop_burst;
      gap = draw_gap(pop_burst);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty buffer, field extremes, duplicate pages
    send_request(CMD_LOOKUP, 8'h00, 8'h00);
    send_request(CMD_LOOKUP, 8'hFF, 8'hFF);
    send_request(CMD_INSERT, 8'h00, 8'hFF);
    send_request(CMD_INSERT, 8'hFF, 8'h00);
    send_request(CMD_INSERT, 8'hFF, 8'hA5);
    send_request(CMD_LOOKUP, 8'hFF, 8'h00);
    send_request(CMD_LOOKUP, 8'h00, 8'hFF);
    send_request(CMD_LOOKUP, 8'h07, 8'h5A);
    settle();

    // ring overwrites slots filled by age inserts
    write_policy(POLICY_RING);
    send_request(CMD_INSERT, 8'h00, 8'h01);
    send_request(CMD_INSERT, 8'h80, 8'h80);
    send_request(CMD_LOOKUP, 8'h00, 8'h00);
    send_request(CMD_LOOKUP, 8'hFF, 8'h00);
    send_request(CMD_LOOKUP, 8'h80, 8'hFF);
    settle();

    // back to age fill, which ignores the ring pointer
    write_policy(POLICY_AGE);
    send_request(CMD_INSERT, 8'h01, 8'h7F);
    send_request(CMD_LOOKUP, 8'h01, 8'h00);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      write_policy((p % 2 == 0) ? POLICY_RING : POLICY_AGE);
      run_phase(RANDOM_ITEMS / PHASES);
      settle();
    end

    $display("checked %0d results of %0d requests: %0d lookup hits, %0d full-buffer replacements",
             checked, sent, hits, evictions);
    $display("replacement policy written %0d times, with random idling on both sides",
             policy_writes);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
